// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SOLS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SOLS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SOLS_ASSERT(label, clk, rst_n, prop)
`define SOLS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/sols_pkg.sv =====
// ----------------------------------------------------------------------------
// sols_pkg
// Shared types and constants of the self-organizing list search block.
// ----------------------------------------------------------------------------
package sols_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int PL_W         = 32;
  localparam int HIT_W        = 8;
  localparam int POS_W        = 6;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic [HIT_W-1:0] HIT_MAX      = 8'hFF;
  localparam logic [HIT_W-1:0] THRESH_RESET = 8'd3;

  // Configuration word index (paddr[2])
  localparam logic REG_THRESH = 1'b0;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_SEARCH = 1'b0,
    OP_INSERT = 1'b1
  } opcode_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PL_W-1:0]         payload;
    logic [HIT_W-1:0]        hits;
  } entry_t;

  typedef struct packed {
    logic load;   // take the broadcast entry
    logic shift;  // take the predecessor's entry
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sols_cell.sv =====
// ----------------------------------------------------------------------------
// sols_cell
// One list slot: holds an entry, compares it to the search key, and loads
// either the broadcast entry or its predecessor's entry.
// ----------------------------------------------------------------------------
module sols_cell (
  input  logic                           clk,
  input  sols_pkg::cell_ctrl_t           ctrl_i,
  input  sols_pkg::entry_t               prev_i,
  input  sols_pkg::entry_t               bcast_i,
  input  logic signed [sols_pkg::KEY_W-1:0] key_i,
  output sols_pkg::entry_t               q_o,
  output logic                           match_o
);
  import sols_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      ent_r <= bcast_i;
    end else if (ctrl_i.shift) begin
      ent_r <= prev_i;
    end
  end

  assign q_o     = ent_r;
  assign match_o = (ent_r.key == key_i);

endmodule

// ===== rtl/core/self_organizing_list_search.sv =====
// ----------------------------------------------------------------------------
// self_organizing_list_search
// Bounded self-organizing list (transpose / move-to-front) built as a chain
// of slot cells with a broadcast key compare.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+------------------------------------
//  input    | in_valid / in_ready          | in_opcode, in_key, in_payload
//  result   | out_valid / out_ready        | out_status, out_position,
//           |                              | out_found_payload, out_hit_count
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
//  Steps: an insert is accepted, then written to the slot past the tail unless
//  the list is full; a search runs accept, key compare in all cells, first-match
//  select, gather of the hit entry and move/swap in the chain. The first-match select and the
//  gather over all cells set the search latency.
//  Reset: rst_n is synchronous, active low; it empties the list and sets
//  promote_threshold to 3. No clearing pass: slot contents need no reset.
//  Stalls: one result register; while it is occupied and out_ready is low
//  the block holds its final step and accepts nothing new.
//
`include "assert_macros.svh"

module self_organizing_list_search #(
  parameter int CAPACITY = sols_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic signed [sols_pkg::KEY_W-1:0] in_key,
  input  logic [sols_pkg::PL_W-1:0]         in_payload,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [sols_pkg::POS_W-1:0]        out_position,
  output logic [sols_pkg::PL_W-1:0]         out_found_payload,
  output logic [sols_pkg::HIT_W-1:0]        out_hit_count,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sols_pkg::CFG_AW-1:0]       paddr,
  input  logic [sols_pkg::CFG_DW-1:0]       pwdata,
  output logic [sols_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready
);
  import sols_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CAPACITY-1:0] FRONT_BIT = CAPACITY'(1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_SEL  = 5'b00100,
    ST_READ = 5'b01000,
    ST_MOVE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // command held for the whole transaction
  logic                    cmd_op_r;
  logic signed [KEY_W-1:0] cmd_key_r;
  logic [PL_W-1:0]         cmd_pl_r;

  logic [CAPACITY-1:0] match_r, onehot_r, prior_r;
  logic [CAPACITY-1:0] match_raw, valid_vec;
  logic [PL_W-1:0]     hit_pl_r, gath_pl;
  logic [HIT_W-1:0]    hit_h_r, gath_h, h_new;
  logic [CW-1:0]       pos_r, gath_pos;
  logic [CW-1:0]       total_r, total_nxt;
  logic [HIT_W-1:0]    thr_r;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;
  logic [PL_W-1:0]     out_pl_r, out_pl_nxt;
  logic [HIT_W-1:0]    out_hc_r, out_hc_nxt;

  logic                slot_free, found, promote;
  logic [CAPACITY-1:0] ld_vec, sh_vec, ins_vec;
  entry_t              bcast;
  entry_t              cell_q [CAPACITY];

  // ---------------------------------------------------------------------------
  // Chain of slots: slot 0 is the front of the list
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    entry_t     prev;
    cell_ctrl_t ctrl;

    if (g == 0) begin : g_front
      assign prev = '0;
    end else begin : g_rest
      assign prev = cell_q[g-1];
    end

    assign ctrl.load    = ld_vec[g];
    assign ctrl.shift   = sh_vec[g];
    // slot holds a live entry when it sits below the fill count
    assign valid_vec[g] = (CW'(g) < total_r);
    // insert lands on the slot just past the tail
    assign ins_vec[g]   = (CW'(g) == total_r);

    sols_cell u_slot (
      .clk     (clk),
      .ctrl_i  (ctrl),
      .prev_i  (prev),
      .bcast_i (bcast),
      .key_i   (cmd_key_r),
      .q_o     (cell_q[g]),
      .match_o (match_raw[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Gather the selected entry (one-hot select, OR over slots)
  // ---------------------------------------------------------------------------
  always_comb begin
    gath_pl  = '0;
    gath_h   = '0;
    gath_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (onehot_r[i]) begin
        gath_pl  = gath_pl | cell_q[i].payload;
        gath_h   = gath_h | cell_q[i].hits;
        gath_pos = gath_pos | CW'(i + 1);
      end
    end
  end

  assign found     = |onehot_r;
  assign h_new     = (hit_h_r == HIT_MAX) ? hit_h_r : hit_h_r + HIT_W'(1);
  // above the threshold the hit entry jumps to the front
  assign promote   = (h_new > thr_r);
  assign slot_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Sequencer and chain control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    ld_vec         = '0;
    sh_vec         = '0;
    bcast.key      = cmd_key_r;
    bcast.payload  = cmd_pl_r;
    bcast.hits     = '0;
    // drop the result once it is taken
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_pl_nxt     = out_pl_r;
    out_hc_nxt     = out_hc_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (cmd_op_r == OP_INSERT) begin
          if (slot_free) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_pl_nxt    = '0;
            out_hc_nxt    = '0;
            if (total_r == CW'(CAPACITY)) begin
              out_status_nxt = ST_FULL;
              out_pos_nxt    = '0;
            end else begin
              ld_vec         = ins_vec;
              total_nxt      = total_r + CW'(1);
              out_status_nxt = ST_INSERTED;
              out_pos_nxt    = POS_W'(total_r + CW'(1));
            end
          end
        end else begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          bcast.payload = hit_pl_r;
          bcast.hits    = h_new;
          if (found) begin
            out_status_nxt = ST_HIT;
            out_pos_nxt    = POS_W'(pos_r);
            out_pl_nxt     = hit_pl_r;
            out_hc_nxt     = h_new;
            priority if (onehot_r[0]) begin
              // hit at the front: update the count in place
              ld_vec = onehot_r;
            end else if (!promote) begin
              // transpose with the predecessor
              sh_vec = onehot_r;
              ld_vec = onehot_r >> 1;
            end else begin
              // move to front: everything ahead of the hit shifts back
              sh_vec = (prior_r | onehot_r) & ~FRONT_BIT;
              ld_vec = FRONT_BIT;
            end
          end else begin
            out_status_nxt = ST_MISS;
            out_pos_nxt    = '0;
            out_pl_nxt     = '0;
            out_hc_nxt     = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THRESH_RESET;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && (paddr[2] == REG_THRESH)) begin
        thr_r <= pwdata[HIT_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_op_r  <= in_opcode;
      cmd_key_r <= in_key;
      cmd_pl_r  <= in_payload;
    end
    if (state_r == ST_CMP) begin
      match_r <= match_raw & valid_vec;
    end
    if (state_r == ST_SEL) begin
      // isolate the first match from the front
      onehot_r <= match_r & (~match_r + CAPACITY'(1));
    end
    if (state_r == ST_READ) begin
      prior_r  <= onehot_r - CAPACITY'(1);
      hit_pl_r <= gath_pl;
      hit_h_r  <= gath_h;
      pos_r    <= gath_pos;
    end
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_pl_r     <= out_pl_nxt;
    out_hc_r     <= out_hc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_position      = out_pos_r;
  assign out_found_payload = out_pl_r;
  assign out_hit_count     = out_hc_r;

  // configuration read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESH) ? CFG_DW'(thr_r) : '0;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SOLS_ASSERT(a_sel_onehot, clk, rst_n, (state_r == ST_READ) |-> $onehot0(onehot_r))
  `SOLS_ASSERT_NEVER(a_total_bound, clk, rst_n, total_r > CW'(CAPACITY))
  `SOLS_ASSERT(a_result_src, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_CMP) || ($past(state_r) == ST_MOVE))
  `SOLS_ASSERT(a_total_only_insert, clk, rst_n, (state_r != ST_CMP) |=> $stable(total_r))
  `SOLS_ASSERT(a_miss_keeps_total, clk, rst_n, (state_r == ST_MOVE) && !found |=> $stable(total_r))

endmodule

// ===== dv/self_organizing_list_search_tb.sv =====
// ----------------------------------------------------------------------------
// self_organizing_list_search_tb
// Drives inserts and key searches through the self-organizing list with
// random idling on both channels and checks every result against an
// in-bench list predictor, across several promote_threshold settings.
// ----------------------------------------------------------------------------
module self_organizing_list_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sols_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam logic [CFG_AW-1:0] THRESH_ADDR = CFG_AW'(4 * REG_THRESH);
  localparam logic [KEY_W-1:0] HOT_KEY = 32'h7FFF_FFFF;

  typedef struct {
    opcode_t          opcode;
    logic [KEY_W-1:0] key;
    logic [PL_W-1:0]  payload;
  } list_item_t;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [PL_W-1:0]  found_payload;
    logic [HIT_W-1:0] hit_count;
  } list_result_t;

  // DUT connections; every input starts at a known value
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_opcode = 1'b0;
  logic signed [KEY_W-1:0]  in_key = '0;
  logic [PL_W-1:0]          in_payload = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic [POS_W-1:0]         out_position;
  logic [PL_W-1:0]          out_found_payload;
  logic [HIT_W-1:0]         out_hit_count;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_AW-1:0]        paddr = '0;
  logic [CFG_DW-1:0]        pwdata = '0;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;

  // Predictor state: list cells, occupancy and the threshold register
  entry_t           list_cells [LIST_DEPTH];
  int               cell_total = 0;
  logic [HIT_W-1:0] promote_level = THRESH_RESET;

  // Stimulus bookkeeping
  list_item_t       pending_items [$];
  list_result_t     due_results [$];
  logic [KEY_W-1:0] present_keys [$];   // keys the list will hold, in insert order
  int               planned_total = 0;
  bit               idling_on = 1'b1;
  int               mismatch_count = 0;

  // Driver and monitor working variables
  list_item_t       in_flight;
  list_result_t     due_result;
  int               in_gap_left = 0;
  int               out_gap_left = 0;

  self_organizing_list_search i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_key            (in_key),
    .in_payload        (in_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_position      (out_position),
    .out_found_payload (out_found_payload),
    .out_hit_count     (out_hit_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Apply one transaction to the predicted list and return its result.
  // A miss or a full insert leaves the list untouched.
  function automatic list_result_t apply_list_op(input list_item_t it);
    list_result_t     res;
    int               hit_idx;
    logic [HIT_W-1:0] hits;
    entry_t           moved;
    res.status        = ST_MISS;
    res.position      = '0;
    res.found_payload = '0;
    res.hit_count     = '0;
    if (it.opcode == OP_INSERT) begin
      if (cell_total >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        list_cells[cell_total].key     = it.key;
        list_cells[cell_total].payload = it.payload;
        list_cells[cell_total].hits    = '0;
        cell_total++;
        res.status   = ST_INSERTED;
        res.position = POS_W'(cell_total);
      end
      return res;
    end
    // first match from the front wins, so duplicates behind it stay hidden
    hit_idx = -1;
    for (int i = 0; i < cell_total; i++) begin
      if (hit_idx < 0 && list_cells[i].key == it.key) hit_idx = i;
    end
    if (hit_idx < 0) return res;
    hits = list_cells[hit_idx].hits;
    if (hits != HIT_MAX) hits = hits + 1'b1;
    moved      = list_cells[hit_idx];
    moved.hits = hits;
    res.status        = ST_HIT;
    res.position      = POS_W'(hit_idx + 1);
    res.found_payload = moved.payload;
    res.hit_count     = hits;
    if (hit_idx == 0) begin
      list_cells[0] = moved;
    end else if (hits <= promote_level) begin
      // transpose with the predecessor
      list_cells[hit_idx]     = list_cells[hit_idx - 1];
      list_cells[hit_idx - 1] = moved;
    end else begin
      // move to front, shift the ones ahead of it back by one
      for (int i = hit_idx; i > 0; i--) list_cells[i] = list_cells[i - 1];
      list_cells[0] = moved;
    end
    return res;
  endfunction

  // Driver: hold the current transaction until accepted, predict it on
  // acceptance, then either idle for a burst or present the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(apply_list_op(in_flight));
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && idling_on &&
                     $urandom_range(0, 99) < 12) begin
          in_gap_left = $urandom_range(0, 15);
          in_valid    <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_flight  = pending_items.pop_front();
          in_valid   <= 1'b1;
          in_opcode  <= in_flight.opcode;
          in_key     <= in_flight.key;
          in_payload <= in_flight.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation and
  // stall out_ready in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      out_gap_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status=%0d pos=%0d",
                                  out_status, out_position));
        end else begin
          due_result = due_results.pop_front();
          if (out_status !== due_result.status)
            flag_mismatch($sformatf("status %0d, want %s", out_status,
                                    due_result.status.name()));
          if (out_position !== due_result.position)
            flag_mismatch($sformatf("position %0d, want %0d", out_position,
                                    due_result.position));
          if (out_found_payload !== due_result.found_payload)
            flag_mismatch($sformatf("found_payload %h, want %h", out_found_payload,
                                    due_result.found_payload));
          if (out_hit_count !== due_result.hit_count)
            flag_mismatch($sformatf("hit_count %0d, want %0d", out_hit_count,
                                    due_result.hit_count));
        end
      end
      if (out_gap_left > 0) begin
        out_gap_left--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 99) < 12) begin
        out_gap_left = $urandom_range(0, 15);
        out_ready    <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Queue one transaction and track which keys the list will end up holding.
  task automatic queue_item(input opcode_t op, input logic [KEY_W-1:0] key,
                            input logic [PL_W-1:0] payload);
    list_item_t it;
    it.opcode  = op;
    it.key     = key;
    it.payload = payload;
    pending_items.push_back(it);
    if (op == OP_INSERT && planned_total < LIST_DEPTH) begin
      present_keys.push_back(key);
      planned_total++;
    end
  endtask

  // Hold off until every queued transaction has been accepted and every
  // result has arrived, then let the pipeline settle.
  task automatic wait_list_idle();
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB read of the threshold register, checked against the predictor.
  task automatic check_threshold_readback();
    logic [CFG_DW-1:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= THRESH_ADDR;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== CFG_DW'(promote_level))
      flag_mismatch($sformatf("threshold readback %h, want %h", rd, promote_level));
  endtask

  // APB write of the threshold register; upper data bits carry noise.
  task automatic set_promote_threshold(input logic [HIT_W-1:0] level);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= THRESH_ADDR;
    pwdata  <= {24'($urandom_range(0, 32'h00FF_FFFF)), 8'h00} | CFG_DW'(level);
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    promote_level = level;
    check_threshold_readback();
  endtask

  // Mostly searches for held keys, one of them hot so its count saturates;
  // the rest are inserts (some duplicates) and searches that miss.
  task automatic queue_random_items(input int count, input int insert_pct);
    int               pick;
    logic [KEY_W-1:0] key;
    @(negedge clk);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) begin
        if ($urandom_range(0, 9) == 0)
          key = present_keys[$urandom_range(0, present_keys.size() - 1)];
        else
          key = $urandom();
        queue_item(OP_INSERT, key, $urandom());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          key = HOT_KEY;
        else if (pick < 85)
          key = present_keys[$urandom_range(0, present_keys.size() - 1)];
        else
          key = $urandom();
        queue_item(OP_SEARCH, key, $urandom());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_threshold_readback();

    // Directed opening at the reset threshold.
    @(negedge clk);
    queue_item(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);  // empty list: miss
    queue_item(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_item(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    queue_item(OP_INSERT, 32'h0000_0000, 32'h5A5A_5A5A);
    queue_item(OP_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);  // duplicate key
    queue_item(OP_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);  // hit at the front
    queue_item(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);  // first of the duplicates
    queue_item(OP_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // walk two entries to the front by transposes; the second then counts past the threshold
    queue_item(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    queue_item(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    queue_item(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    queue_item(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_item(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);  // count 4, already at the front
    queue_item(OP_SEARCH, 32'h1357_9BDF, 32'h0000_0000);  // miss
    wait_list_idle();

    // Every hit past the front moves to the front; the list fills up here.
    set_promote_threshold(8'd0);
    queue_random_items(200, 15);
    wait_list_idle();

    // Only transposes, even at a saturated count.
    set_promote_threshold(8'd255);
    queue_random_items(200, 15);
    wait_list_idle();

    set_promote_threshold(HIT_W'($urandom_range(2, 254)));
    queue_random_items(200, 15);
    wait_list_idle();

    set_promote_threshold(8'd1);
    queue_random_items(200, 15);
    wait_list_idle();

    // Saturated count just above the threshold; drop idling for the tail.
    set_promote_threshold(8'd254);
    queue_random_items(110, 15);
    wait_list_idle();
    @(negedge clk);
    idling_on = 1'b0;
    queue_random_items(110, 15);
    wait_list_idle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("self_organizing_list_search_tb: clean");
    end else begin
      $display("self_organizing_list_search_tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("self_organizing_list_search_tb: errors");
    $finish;
  end

endmodule
